>>> rtl/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, constants and the Paeth predictor for the scanline unfilter.
// ----------------------------------------------------------------------------
package psu_pkg;

	localparam int MAX_ROW_BYTES   = 8192;
	localparam int MAX_PIXEL_BYTES = 8;

	localparam int COL_W  = $clog2(MAX_ROW_BYTES);
	localparam int HIST_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
	localparam int BPP_W  = 4;
	localparam int RB_W   = 14;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES       = 1'd1;

	typedef enum logic [2:0] {
		FILT_NONE    = 3'd0,
		FILT_SUB     = 3'd1,
		FILT_UP      = 3'd2,
		FILT_AVG     = 3'd3,
		FILT_PAETH   = 3'd4,
		FILT_UNKNOWN = 3'd5
	} filter_t;

	// One beat in flight between column tracking and reconstruction
	typedef struct packed {
		logic             is_filter;
		logic [7:0]       data;
		logic [COL_W-1:0] col;
		logic             row_end;
		logic             first_row;
	} item_t;

	function automatic filter_t decode_filter(input logic [7:0] code);
		filter_t f;
		if (code > 8'd4)
			f = FILT_UNKNOWN;
		else
			f = filter_t'(code[2:0]);
		return f;
	endfunction

	// Ties go to a, then b, then c
	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [9:0] d_bc;
		logic signed [9:0] d_ac;
		logic signed [9:0] d_sum;
		logic [9:0]        pa;
		logic [9:0]        pb;
		logic [9:0]        pc;
		logic [7:0]        pick;
		d_bc  = signed'({2'b00, b}) - signed'({2'b00, c});
		d_ac  = signed'({2'b00, a}) - signed'({2'b00, c});
		d_sum = d_bc + d_ac;
		pa = (d_bc < 0) ? unsigned'(-d_bc) : unsigned'(d_bc);
		pb = (d_ac < 0) ? unsigned'(-d_ac) : unsigned'(d_ac);
		pc = (d_sum < 0) ? unsigned'(-d_sum) : unsigned'(d_sum);
		if (pa <= pb && pa <= pc)
			pick = a;
		else if (pb <= pc)
			pick = b;
		else
			pick = c;
		return pick;
	endfunction

endpackage

>>> rtl/psu_if.sv
// ----------------------------------------------------------------------------
// psu_if
// Valid/ready channels of the scanline unfilter: stream in, stream out, config.
// ----------------------------------------------------------------------------
interface psu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_image;

	modport source(output valid, output data_byte, output start_image, input ready);
	modport sink(input valid, input data_byte, input start_image, output ready);
endinterface

interface psu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic       row_end;

	modport source(output valid, output pixel_byte, output row_end, input ready);
	modport sink(input valid, input pixel_byte, input row_end, output ready);
endinterface

interface psu_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [psu_pkg::CFG_IDX_W-1:0]   index;
	logic [psu_pkg::CFG_DATA_W-1:0]  wdata;

	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface

>>> rtl/psu_line_ram.sv
// ----------------------------------------------------------------------------
// psu_line_ram
// Single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module psu_line_ram #(
	parameter int DEPTH = 8192,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/psu_ctrl.sv
// ----------------------------------------------------------------------------
// psu_ctrl
// Column tracking: filter byte / data byte split, row end, first-row flag,
// line store read issue and the stage-1 register.
// ----------------------------------------------------------------------------
module psu_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	psu_in_if.sink                      px_in,
	input  logic [psu_pkg::COL_W-1:0]   rbm1,
	input  logic                        s1_fire,
	output psu_pkg::item_t              item_s1,
	output logic                        valid_s1,
	output logic                        load,
	output logic [psu_pkg::COL_W-1:0]   rd_addr
);

	logic                      expect_q;
	logic [psu_pkg::COL_W-1:0] col_q;
	logic                      first_row_q;
	psu_pkg::item_t            item_s0;

	assign px_in.ready = !valid_s1 || s1_fire;
	assign load        = px_in.valid && px_in.ready;
	assign rd_addr     = col_q;

	always_comb begin
		item_s0.is_filter = px_in.start_image || expect_q;
		item_s0.data      = px_in.data_byte;
		item_s0.col       = col_q;
		item_s0.row_end   = !item_s0.is_filter && (col_q >= rbm1);
		item_s0.first_row = first_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q    <= 1'b1;
			col_q       <= '0;
			first_row_q <= 1'b1;
			valid_s1    <= 1'b0;
		end else begin
			if (load) begin
				if (item_s0.is_filter) begin
					expect_q <= 1'b0;
					col_q    <= '0;
					if (px_in.start_image)
						first_row_q <= 1'b1;
				end else if (item_s0.row_end) begin
					expect_q    <= 1'b1;
					col_q       <= '0;
					first_row_q <= 1'b0;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (load)
				valid_s1 <= 1'b1;
			else if (s1_fire)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			item_s1 <= item_s0;
	end

endmodule

>>> rtl/psu_recon.sv
// ----------------------------------------------------------------------------
// psu_recon
// Byte reconstruction: filter arithmetic against left, above and upper-left
// bytes, pixel history, line store write-back and the output register.
// ----------------------------------------------------------------------------
module psu_recon (
	input  logic                         clk,
	input  logic                         arst_n,
	input  psu_pkg::item_t               item_s1,
	input  logic                         valid_s1,
	input  logic                         load,
	input  logic [psu_pkg::HIST_W-1:0]   bpp_sel,
	input  logic [7:0]                   rd_data,
	psu_out_if.source                    px_out,
	output logic                         s1_fire,
	output logic                         wr_en,
	output logic [psu_pkg::COL_W-1:0]    wr_addr,
	output logic [7:0]                   wr_data
);

	psu_pkg::filter_t row_filter_q;
	logic [7:0]       left_q [psu_pkg::MAX_PIXEL_BYTES];
	logic [7:0]       up_q   [psu_pkg::MAX_PIXEL_BYTES];
	logic             fresh_q;
	logic [7:0]       b_hold_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_end_q;

	logic [7:0] b_raw;
	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] c;
	logic [8:0] avg_sum;
	logic [7:0] pred;
	logic [7:0] v;

	// RAM data is valid only in the cycle after the read; hold it across stalls
	assign b_raw = fresh_q ? rd_data : b_hold_q;
	assign b     = item_s1.first_row ? 8'd0 : b_raw;
	assign a     = left_q[bpp_sel];
	assign c     = up_q[bpp_sel];
	assign avg_sum = {1'b0, a} + {1'b0, b};

	always_comb begin
		case (row_filter_q)
			psu_pkg::FILT_SUB:   pred = a;
			psu_pkg::FILT_UP:    pred = b;
			psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
			psu_pkg::FILT_PAETH: pred = psu_pkg::paeth_pick(a, b, c);
			default:             pred = 8'd0;
		endcase
	end

	assign v = item_s1.data + pred;

	assign s1_fire = valid_s1 && (!out_valid_q || px_out.ready);
	assign wr_en   = s1_fire && !item_s1.is_filter;
	assign wr_addr = item_s1.col;
	assign wr_data = v;

	assign px_out.valid      = out_valid_q;
	assign px_out.pixel_byte = out_byte_q;
	assign px_out.row_end    = out_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_filter_q <= psu_pkg::FILT_NONE;
			fresh_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int k = 0; k < psu_pkg::MAX_PIXEL_BYTES; k++) begin
				left_q[k] <= 8'd0;
				up_q[k]   <= 8'd0;
			end
		end else begin
			fresh_q <= load;
			if (s1_fire) begin
				if (item_s1.is_filter) begin
					row_filter_q <= psu_pkg::decode_filter(item_s1.data);
					for (int k = 0; k < psu_pkg::MAX_PIXEL_BYTES; k++) begin
						left_q[k] <= 8'd0;
						up_q[k]   <= 8'd0;
					end
				end else begin
					for (int k = psu_pkg::MAX_PIXEL_BYTES - 1; k > 0; k--) begin
						left_q[k] <= left_q[k-1];
						up_q[k]   <= up_q[k-1];
					end
					left_q[0] <= v;
					up_q[0]   <= b;
				end
			end
			if (s1_fire && !item_s1.is_filter)
				out_valid_q <= 1'b1;
			else if (px_out.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		b_hold_q <= b_raw;
		if (s1_fire && !item_s1.is_filter) begin
			out_byte_q <= v;
			out_end_q  <= item_s1.row_end;
		end
	end

endmodule

>>> rtl/png_scanline_unfilter_core.sv
// Path: an accepted data beat passes the stage-1 and then the output register.
// Throughput: one stream byte per cycle unless the output stalls; line store
// read in stage 0 and write-back in stage 1 keep a read-modify-write per cycle.
// Reset: control state, pixel history and config registers (both 1) clear at
// once; the line store is not cleared, no start-up pass is needed.
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core
// PNG scanline reconstruction (None/Sub/Up/Average/Paeth) over a line store.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_core (
	input  logic       clk,
	input  logic       arst_n,
	psu_in_if.sink     px_in,
	psu_out_if.source  px_out,
	psu_cfg_if.sink    cfg
);

	logic [psu_pkg::BPP_W-1:0]  bpp_q;
	logic [psu_pkg::RB_W-1:0]   row_bytes_q;
	logic [psu_pkg::HIST_W-1:0] bpp_sel;
	logic [psu_pkg::COL_W-1:0]  rbm1;

	psu_pkg::item_t             item_s1;
	logic                       valid_s1;
	logic                       load;
	logic                       s1_fire;
	logic [psu_pkg::COL_W-1:0]  rd_addr;
	logic [7:0]                 rd_data;
	logic                       wr_en;
	logic [psu_pkg::COL_W-1:0]  wr_addr;
	logic [7:0]                 wr_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q       <= psu_pkg::BPP_W'(1);
			row_bytes_q <= psu_pkg::RB_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				psu_pkg::REG_BYTES_PER_PIXEL: bpp_q <= cfg.wdata[psu_pkg::BPP_W-1:0];
				psu_pkg::REG_ROW_BYTES:       row_bytes_q <= cfg.wdata[psu_pkg::RB_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp registers to their legal ranges; both are kept minus one
	always_comb begin
		if (bpp_q == '0)
			bpp_sel = '0;
		else if (bpp_q > psu_pkg::BPP_W'(psu_pkg::MAX_PIXEL_BYTES))
			bpp_sel = psu_pkg::HIST_W'(psu_pkg::MAX_PIXEL_BYTES - 1);
		else
			bpp_sel = psu_pkg::HIST_W'(bpp_q - 1'b1);

		if (row_bytes_q == '0)
			rbm1 = '0;
		else if (row_bytes_q > psu_pkg::RB_W'(psu_pkg::MAX_ROW_BYTES))
			rbm1 = psu_pkg::COL_W'(psu_pkg::MAX_ROW_BYTES - 1);
		else
			rbm1 = psu_pkg::COL_W'(row_bytes_q - 1'b1);
	end

	psu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.px_in    (px_in),
		.rbm1     (rbm1),
		.s1_fire  (s1_fire),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1),
		.load     (load),
		.rd_addr  (rd_addr)
	);

	psu_line_ram #(
		.DEPTH (psu_pkg::MAX_ROW_BYTES),
		.WIDTH (8)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (load),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	psu_recon u_recon (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1),
		.load     (load),
		.bpp_sel  (bpp_sel),
		.rd_data  (rd_data),
		.px_out   (px_out),
		.s1_fire  (s1_fire),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

endmodule

>>> rtl/psu_checker.sv
// ----------------------------------------------------------------------------
// psu_checker
// Port-level checks on the scanline unfilter, bound to the top level.
// ----------------------------------------------------------------------------
module psu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_pixel_byte,
	input logic       out_row_end
);

	// a result beat never disappears before it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_pixel_byte) && $stable(out_row_end))
		else $error("result payload changed while stalled");

	// a fresh result comes from an input beat accepted earlier
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result beat without matching input beat");

	// a draining output never back-pressures the input
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is draining");

endmodule

bind png_scanline_unfilter_core psu_checker u_psu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (px_in.valid),
	.in_ready       (px_in.ready),
	.out_valid      (px_out.valid),
	.out_ready      (px_out.ready),
	.out_pixel_byte (px_out.pixel_byte),
	.out_row_end    (px_out.row_end)
);
